@@ sv/klt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_pkg
// Shared types, codes and the layout map for the keycode layout translator.
// ----------------------------------------------------------------------------
package klt_pkg;

   localparam logic [1:0] OP_KEY     = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_SERVICE = 2'd2;
   localparam logic [1:0] OP_EURO    = 2'd3;

   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_DEAD   = 2'd1;
   localparam logic [1:0] CSR_HOLD   = 2'd2;
   localparam logic [1:0] CSR_GAP    = 2'd3;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [1:0] DEAD_NONE  = 2'd0;
   localparam logic [1:0] DEAD_ACUTE = 2'd1;
   localparam logic [1:0] DEAD_DIA   = 2'd2;

   localparam logic [3:0] FL_SH  = 4'h1;
   localparam logic [3:0] FL_AG  = 4'h2;
   localparam logic [3:0] FL_ACU = 4'h4;
   localparam logic [3:0] FL_DIA = 4'h8;
   localparam logic [2:0] FL_RAW = 3'h4;

   localparam logic [7:0] SHIFT_BITS = 8'h22;
   localparam logic [7:0] OTHER_BITS = 8'hDD;

   localparam logic [7:0] KEY_DIA_SYM   = 8'h2F;
   localparam logic [7:0] KEY_DIA_BARE  = 8'h20;
   localparam logic [7:0] KEY_ACU_BARE  = 8'h21;
   localparam logic [7:0] KEY_E_ACUTE   = 8'h1F;
   localparam logic [7:0] KEY_C_CEDILLA = 8'h26;
   localparam logic [7:0] KEY_EURO      = 8'h08;

   typedef struct packed {
      logic [7:0] key;
      logic [3:0] flags;
   } map_entry_type;

   typedef struct packed {
      logic       handled;
      logic [1:0] key_action;
      logic [7:0] report_key;
      logic       mods_update;
      logic [7:0] weak_mods;
      logic [7:0] mods_mask;
      logic       send_report;
   } rsp_type;

   // row = keycode - 0x04
   function automatic map_entry_type map_lookup(input logic [5:0] row, input logic st);
      logic [23:0] e;
      begin
         unique case (row)
            6'd0:  e = {8'h14,8'h14,4'd0,4'd1};
            6'd1:  e = {8'h05,8'h05,4'd0,4'd1};
            6'd2:  e = {8'h06,8'h06,4'd0,4'd1};
            6'd3:  e = {8'h07,8'h07,4'd0,4'd1};
            6'd4:  e = {8'h08,8'h08,4'd0,4'd1};
            6'd5:  e = {8'h09,8'h09,4'd0,4'd1};
            6'd6:  e = {8'h0A,8'h0A,4'd0,4'd1};
            6'd7:  e = {8'h0B,8'h0B,4'd0,4'd1};
            6'd8:  e = {8'h0C,8'h0C,4'd0,4'd1};
            6'd9:  e = {8'h0D,8'h0D,4'd0,4'd1};
            6'd10: e = {8'h0E,8'h0E,4'd0,4'd1};
            6'd11: e = {8'h0F,8'h0F,4'd0,4'd1};
            6'd12: e = {8'h33,8'h33,4'd0,4'd1};
            6'd13: e = {8'h11,8'h11,4'd0,4'd1};
            6'd14: e = {8'h12,8'h12,4'd0,4'd1};
            6'd15: e = {8'h13,8'h13,4'd0,4'd1};
            6'd16: e = {8'h04,8'h04,4'd0,4'd1};
            6'd17: e = {8'h15,8'h15,4'd0,4'd1};
            6'd18: e = {8'h16,8'h16,4'd0,4'd1};
            6'd19: e = {8'h17,8'h17,4'd0,4'd1};
            6'd20: e = {8'h18,8'h18,4'd0,4'd1};
            6'd21: e = {8'h19,8'h19,4'd0,4'd1};
            6'd22: e = {8'h1D,8'h1D,4'd0,4'd1};
            6'd23: e = {8'h1B,8'h1B,4'd0,4'd1};
            6'd24: e = {8'h1C,8'h1C,4'd0,4'd1};
            6'd25: e = {8'h1A,8'h1A,4'd0,4'd1};
            6'd26: e = {8'h1E,8'h38,4'd1,4'd0};
            6'd27: e = {8'h1F,8'h27,4'd1,4'd2};
            6'd28: e = {8'h20,8'h20,4'd1,4'd2};
            6'd29: e = {8'h21,8'h30,4'd1,4'd0};
            6'd30: e = {8'h22,8'h34,4'd1,4'd1};
            6'd31: e = {8'h23,8'h2F,4'd1,4'd0};
            6'd32: e = {8'h24,8'h1E,4'd1,4'd0};
            6'd33: e = {8'h25,8'h31,4'd1,4'd0};
            6'd34: e = {8'h26,8'h22,4'd1,4'd0};
            6'd35: e = {8'h27,8'h2D,4'd1,4'd0};
            6'd36: e = {8'h28,8'h28,4'd0,4'd0};
            6'd37: e = {8'h29,8'h29,4'd0,4'd0};
            6'd38: e = {8'h2A,8'h2A,4'd0,4'd0};
            6'd39: e = {8'h2B,8'h2B,4'd0,4'd0};
            6'd40: e = {8'h2C,8'h2C,4'd0,4'd0};
            6'd41: e = {8'h23,8'h25,4'd0,4'd0};
            6'd42: e = {8'h2E,8'h2E,4'd0,4'd1};
            6'd43: e = {8'h22,8'h21,4'd2,4'd2};
            6'd44: e = {8'h2D,8'h2E,4'd2,4'd2};
            6'd45: e = {8'h25,8'h23,4'd2,4'd2};
            6'd46: e = {8'h32,8'h32,4'd0,4'd0};
            6'd47: e = {8'h36,8'h37,4'd0,4'd0};
            6'd48: e = {8'h21,8'h20,4'd4,4'd8};
            6'd49: e = {8'h24,8'h1F,4'd2,4'd2};
            6'd50: e = {8'h10,8'h64,4'd0,4'd0};
            6'd51: e = {8'h36,8'h64,4'd1,4'd1};
            6'd52: e = {8'h37,8'h10,4'd1,4'd1};
            default: e = '0;
         endcase
         map_lookup.key   = st ? e[15:8] : e[23:16];
         map_lookup.flags = st ? e[3:0]  : e[7:4];
      end
   endfunction

endpackage

@@ sv/klt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface klt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] keycode;
   logic        pressed;
   logic [7:0]  physical_mods;
   modport source (output valid, operation, keycode, pressed, physical_mods, input ready);
   modport sink   (input valid, operation, keycode, pressed, physical_mods, output ready);
endinterface

interface klt_rsp_if;
   logic       valid;
   logic       ready;
   logic       handled;
   logic [1:0] key_action;
   logic [7:0] report_key;
   logic       mods_update;
   logic [7:0] weak_mods;
   logic [7:0] mods_mask;
   logic       send_report;
   modport source (output valid, handled, key_action, report_key, mods_update, weak_mods,
                   mods_mask, send_report, input ready);
   modport sink   (input valid, handled, key_action, report_key, mods_update, weak_mods,
                   mods_mask, send_report, output ready);
endinterface

interface klt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/keycode_layout_translator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keycode_layout_translator_top
// Maps US key events to AZERTY keycodes with held-key table, dead keys and
// a queue of synthetic keystrokes played out over timer ticks.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  req_     | in  | operation, keycode, pressed, physical_mods
//  rsp_     | out | handled, key_action, report_key, mods_update, weak_mods,
//           |     | mods_mask, send_report
//  csr_     | in  | index, data (register write)
//
// an item is accepted in ST_IDLE and passes through ST_SCAN, ST_DONE and ST_OUT
// before the next one is taken: a key event walks the held-key table one entry a
// cycle through a single compare unit until it hits or reaches the last entry,
// other items leave ST_SCAN without a walk. the response waits in an output register and
// the next item is taken once it has gone, so rsp ready low holds the flow. a pending register
// write goes ahead of a request. reset is synchronous and clears all control state.
module keycode_layout_translator_top #(
   parameter int HELD_ENTRIES = 8,
   parameter int QUEUE_DEPTH  = 4
) (
   input logic clock,
   input logic reset,
   klt_req_if.sink   req,
   klt_rsp_if.source rsp,
   klt_csr_if.sink   csr
);
   import klt_pkg::*;

   localparam int HW = (HELD_ENTRIES > 1) ? $clog2(HELD_ENTRIES) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(HELD_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        enable_ff;
   logic [15:0] dead_to_ff;
   logic [7:0]  hold_ff, gap_ff;

   logic [HELD_ENTRIES-1:0][7:0] held_us_ff;
   logic [7:0]  held_em_ff [HELD_ENTRIES];
   logic [CW-1:0] held_cnt_ff;
   logic [2:0]  last_fl_ff;
   logic [7:0]  q_key_ff [QUEUE_DEPTH];
   logic [1:0]  q_fl_ff  [QUEUE_DEPTH];
   logic [QW-1:0] q_head_ff, q_tail_ff;
   logic [1:0]  phase_ff;
   logic [7:0]  play_key_ff, play_wait_ff;
   logic        play_due_ff;
   logic [1:0]  dead_kind_ff;
   logic [15:0] dead_wait_ff;
   logic        dead_due_ff;

   // latched item
   logic [1:0]  op_ff;
   logic [7:0]  us_ff;
   logic        press_ff, shortcut_ff, st_ff, inrange_ff;
   logic [HW-1:0] idx_ff;
   logic        found_ff;
   logic [HW-1:0] hit_ff;
   rsp_type     rsp_ff;

   map_entry_type me;
   assign me = map_lookup(6'(us_ff - 8'h04), st_ff);

   function automatic logic [QW-1:0] qn(input logic [QW-1:0] i);
      return (32'(i) + 1 >= QUEUE_DEPTH) ? '0 : QW'(32'(i) + 1);
   endfunction

   assign req.ready = (state_ff == ST_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.handled     = rsp_ff.handled;
   assign rsp.key_action  = rsp_ff.key_action;
   assign rsp.report_key  = rsp_ff.report_key;
   assign rsp.mods_update = rsp_ff.mods_update;
   assign rsp.weak_mods   = rsp_ff.weak_mods;
   assign rsp.mods_mask   = rsp_ff.mods_mask;
   assign rsp.send_report = rsp_ff.send_report;

   // compare unit: one held entry per cycle
   logic [7:0] probe;
   logic       scan_hit;
   assign probe    = press_ff ? 8'h00 : us_ff;
   assign scan_hit = (held_us_ff[idx_ff] == probe);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid && req.ready) state_in = ST_SCAN;
         ST_SCAN: if (found_ff || scan_hit || 32'(idx_ff) == HELD_ENTRIES - 1
                      || op_ff != OP_KEY) state_in = ST_DONE;
         ST_DONE: state_in = ST_OUT;
         ST_OUT:  if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // register writes, item latch, table walk, and the result and state update done in ST_DONE
   always_ff @(posedge clock) begin
      logic [QW-1:0] t, n, h;
      logic [1:0]    dk;
      logic          busy, up, dpush;
      logic [2:0]    mf;
      rsp_type       r;
      logic [3:0]    f;
      logic [7:0]    k;
      if (reset) begin
         state_ff <= ST_IDLE;
         enable_ff <= 1'b0; dead_to_ff <= 16'd7142; hold_ff <= 8'd8; gap_ff <= 8'd4;
         held_us_ff <= '0; held_cnt_ff <= '0; last_fl_ff <= FL_RAW;
         q_head_ff <= '0; q_tail_ff <= '0; phase_ff <= '0; play_key_ff <= '0;
         play_wait_ff <= '0; play_due_ff <= 1'b0; dead_kind_ff <= DEAD_NONE;
         dead_wait_ff <= '0; dead_due_ff <= 1'b0;
         found_ff <= 1'b0; idx_ff <= '0; hit_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready) begin
            unique case (csr.index)
               CSR_ENABLE: begin
                  enable_ff <= csr.data[0];
                  held_us_ff <= '0; held_cnt_ff <= '0; last_fl_ff <= FL_RAW;
                  q_head_ff <= '0; q_tail_ff <= '0; phase_ff <= '0; play_key_ff <= '0;
                  play_wait_ff <= '0; play_due_ff <= 1'b0; dead_kind_ff <= DEAD_NONE;
                  dead_wait_ff <= '0; dead_due_ff <= 1'b0;
               end
               CSR_DEAD: dead_to_ff <= csr.data;
               CSR_HOLD: hold_ff <= csr.data[7:0];
               CSR_GAP:  gap_ff <= csr.data[7:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req.valid && req.ready) begin
            op_ff <= req.operation;
            us_ff <= req.keycode[7:0];
            press_ff <= req.pressed;
            shortcut_ff <= |(req.physical_mods & OTHER_BITS);
            // a shortcut always reads the unshifted column
            st_ff <= |(req.physical_mods & SHIFT_BITS) && !(|(req.physical_mods & OTHER_BITS));
            inrange_ff <= enable_ff && req.keycode >= 16'h04 && req.keycode <= 16'h38;
            idx_ff <= '0; found_ff <= 1'b0;
         end
         if (state_ff == ST_SCAN && !found_ff) begin
            if (scan_hit) begin found_ff <= 1'b1; hit_ff <= idx_ff; end
            else if (32'(idx_ff) < HELD_ENTRIES - 1) idx_ff <= idx_ff + 1'b1;
         end
         if (state_ff == ST_DONE) begin
            r = '{handled:1'b0, key_action:ACT_NONE, report_key:8'h00, mods_update:1'b0,
                  weak_mods:8'h00, mods_mask:8'hFF, send_report:1'b0};
            t = q_tail_ff; h = q_head_ff; dk = dead_kind_ff;
            up = 1'b0; mf = FL_RAW; dpush = 1'b0;
            f = me.flags; k = me.key;
            busy = (phase_ff != 2'd0) || (q_head_ff != q_tail_ff);
            unique case (op_ff)
               OP_KEY: if (inrange_ff) begin
                  if (!press_ff) begin
                     r.handled = 1'b1; r.key_action = ACT_REMOVE; r.send_report = 1'b1;
                     r.report_key = us_ff;
                     up = 1'b1;
                     mf = (held_cnt_ff != 0) ? last_fl_ff : FL_RAW;
                     if (found_ff) begin
                        held_us_ff[hit_ff] <= 8'h00;
                        if (held_em_ff[hit_ff] != 8'h00) r.report_key = held_em_ff[hit_ff];
                        if (held_cnt_ff != 0) begin
                           held_cnt_ff <= held_cnt_ff - 1'b1;
                           if (held_cnt_ff == CW'(1)) mf = FL_RAW;
                        end
                     end
                  end else if (shortcut_ff) begin
                     dead_kind_ff <= DEAD_NONE;
                     if (found_ff) begin
                        held_us_ff[hit_ff] <= us_ff; held_em_ff[hit_ff] <= k;
                        held_cnt_ff <= held_cnt_ff + 1'b1;
                        r.handled = 1'b1; last_fl_ff <= FL_RAW;
                        r.key_action = ACT_ADD; r.report_key = k; r.send_report = 1'b1;
                        up = 1'b1; mf = FL_RAW;
                     end
                  end else begin
                     r.handled = 1'b1;
                     if (dk != DEAD_NONE) begin
                        dead_kind_ff <= DEAD_NONE; dead_wait_ff <= '0; dead_due_ff <= 1'b0;
                        // up to two pushes
                        for (int p = 0; p < 2; p++) begin
                           logic       doit;
                           logic [7:0] pk;
                           logic [1:0] pf;
                           doit = 1'b0; pk = 8'h00; pf = 2'b00;
                           if (dk == DEAD_DIA) begin
                              if (us_ff <= 8'h1D) begin
                                 doit = 1'b1;
                                 pk = (p == 0) ? KEY_DIA_SYM : k;
                                 pf = (p == 0) ? FL_SH[1:0] : f[1:0];
                              end else begin
                                 doit = (p == 0) || (us_ff != 8'h2C);
                                 pk = (p == 0) ? KEY_DIA_BARE : k;
                                 pf = (p == 0) ? 2'b00 : f[1:0];
                              end
                           end else begin
                              if (!st_ff && us_ff == 8'h08) begin
                                 doit = (p == 0); pk = KEY_E_ACUTE;
                              end else if (!st_ff && us_ff == 8'h06) begin
                                 doit = (p == 0); pk = KEY_C_CEDILLA;
                              end else begin
                                 doit = (p == 0) || (us_ff != 8'h2C);
                                 pk = (p == 0) ? KEY_ACU_BARE : k;
                                 pf = (p == 0) ? 2'b00 : f[1:0];
                              end
                           end
                           n = qn(t);
                           if (doit && n != h) begin
                              q_key_ff[t] <= pk; q_fl_ff[t] <= pf; t = n;
                           end
                        end
                        q_tail_ff <= t;
                     end else if (|(f & (FL_ACU | FL_DIA))) begin
                        dead_kind_ff <= (|(f & FL_DIA)) ? DEAD_DIA : DEAD_ACUTE;
                        dead_wait_ff <= (dead_to_ff != 0) ? dead_to_ff : 16'd1;
                        dead_due_ff <= 1'b0;
                     end else if (busy) begin
                        n = qn(t);
                        if (n != h) begin
                           q_key_ff[t] <= k; q_fl_ff[t] <= f[1:0]; q_tail_ff <= n;
                        end
                     end else if (!found_ff) begin
                        r.handled = 1'b0;
                     end else begin
                        held_us_ff[hit_ff] <= us_ff; held_em_ff[hit_ff] <= k;
                        held_cnt_ff <= held_cnt_ff + 1'b1;
                        last_fl_ff <= {1'b0, f[1:0]};
                        r.key_action = ACT_ADD; r.report_key = k; r.send_report = 1'b1;
                        up = 1'b1; mf = {1'b0, f[1:0]};
                     end
                  end
               end
               OP_TICK: begin
                  if (play_wait_ff != 0) begin
                     play_wait_ff <= play_wait_ff - 1'b1;
                     if (play_wait_ff == 8'd1) play_due_ff <= 1'b1;
                  end
                  if (dead_wait_ff != 0) begin
                     dead_wait_ff <= dead_wait_ff - 1'b1;
                     if (dead_wait_ff == 16'd1) dead_due_ff <= 1'b1;
                  end
               end
               OP_SERVICE: begin
                  if (dead_due_ff) begin
                     dead_due_ff <= 1'b0;
                     if (dk != DEAD_NONE) begin
                        n = qn(t);
                        if (n != h) begin
                           k = (dk == DEAD_DIA) ? KEY_DIA_BARE : KEY_ACU_BARE;
                           q_key_ff[t] <= k;
                           q_fl_ff[t] <= 2'b00; dpush = (t == h); t = n; q_tail_ff <= n;
                        end
                        dead_kind_ff <= DEAD_NONE;
                     end
                  end
                  if (phase_ff == 2'd0) begin
                     if (h != t) begin
                        // a bare symbol pushed into an empty queue plays at once
                        if (!dpush) k = q_key_ff[h];
                        play_key_ff <= k;
                        r.key_action = ACT_ADD; r.report_key = k;
                        r.send_report = 1'b1; up = 1'b1;
                        mf = {1'b0, dpush ? 2'b00 : q_fl_ff[h]};
                        phase_ff <= 2'd1; play_due_ff <= 1'b0;
                        play_wait_ff <= (hold_ff != 0) ? hold_ff : 8'd1;
                     end
                  end else if (play_due_ff) begin
                     play_due_ff <= 1'b0;
                     if (phase_ff == 2'd1) begin
                        r.key_action = ACT_REMOVE; r.report_key = play_key_ff;
                        r.send_report = 1'b1; phase_ff <= 2'd2;
                        play_wait_ff <= (gap_ff != 0) ? gap_ff : 8'd1;
                     end else begin
                        phase_ff <= 2'd0;
                        n = qn(h); q_head_ff <= n;
                        if (n == t) begin
                           up = 1'b1; mf = (held_cnt_ff != 0) ? last_fl_ff : FL_RAW;
                        end
                     end
                  end
               end
               default: begin
                  n = qn(t);
                  if (n != h) begin
                     q_key_ff[t] <= KEY_EURO; q_fl_ff[t] <= FL_AG[1:0]; q_tail_ff <= n;
                  end
               end
            endcase
            if (up) begin
               r.mods_update = 1'b1;
               if (mf[2]) begin
                  r.weak_mods = 8'h00; r.mods_mask = 8'hFF;
               end else begin
                  r.mods_mask = OTHER_BITS;
                  r.weak_mods = {1'b0, mf[1], 4'b0, mf[0], 1'b0};
               end
            end
            rsp_ff <= r;
         end
      end
   end

endmodule
